[rtl/core/trb_pkg.sv]
// Shared types and constants for the trace ring buffer with host drain.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package trb_pkg;

  localparam int LOCAL_SIZE = 8192;
  localparam int FLUSH_SIZE = 1024;

  localparam int LOCAL_AW = $clog2(LOCAL_SIZE);
  localparam int CNT_W    = LOCAL_AW + 1;

  localparam logic [CNT_W-1:0] LOCAL_CNT     = CNT_W'(LOCAL_SIZE);
  localparam logic [CNT_W-1:0] FLUSH_CNT     = CNT_W'(FLUSH_SIZE);
  localparam logic [31:0]      LOCAL_32      = 32'(LOCAL_SIZE);
  localparam logic [31:0]      FLUSH_32      = 32'(FLUSH_SIZE);
  localparam logic [31:0]      HALF_LEVEL    = 32'(LOCAL_SIZE / 2);
  localparam logic [15:0]      MAX_EVENT_LEN = 16'(LOCAL_SIZE / 8);

  // request codes
  localparam logic [1:0] REQ_EVENT  = 2'd0;
  localparam logic [1:0] REQ_ATOMIC = 2'd1;
  localparam logic [1:0] REQ_DRAIN  = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_REJECT      = 3'd1;
  localparam logic [2:0] ST_EMPTY       = 3'd2;
  localparam logic [2:0] ST_REFUSED     = 3'd3;
  localparam logic [2:0] ST_FLUSH_RANGE = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_EN  = 1'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] event_length;
    logic        last_byte;
    logic        dma_refused;
    logic [12:0] flush_index;
  } trb_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        drain_request;
    logic [31:0] copy_host_offset;
    logic [12:0] copy_local_offset;
    logic [13:0] copy_size;
    logic [31:0] available_bytes;
    logic [31:0] overflow_bytes;
    logic [31:0] message_count;
    logic [7:0]  flush_byte;
    logic [13:0] flush_size;
  } trb_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic calc;
    logic commit;
  } trb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_event;
  } trb_stat_t;

endpackage

[rtl/core/trb_ram.sv]
// Generic single-port RAM, synchronous write, registered read.
// No dependencies.
`timescale 1ns / 1ps

module trb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/trb_ctrl.sv]
// Sequencing controller: input/output handshakes and per-item step commands.
// Depends on trb_pkg.
`timescale 1ns / 1ps

module trb_ctrl import trb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  trb_stat_t stat,
  output trb_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_CALC,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  // result register can take a new beat if empty or being drained now
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.prep    = (state == S_PREP);
    cmd.calc    = (state == S_CALC);
    cmd.commit  = (state == S_COMMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result beat takes priority over retiring the old one
      if (state == S_COMMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= stat.is_event ? S_COMMIT : S_CALC;
        end
        S_CALC: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && out_valid && !out_ready) |=> (state == S_COMMIT))
    else $error("commit left while result register still full");

  a_capture_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_PREP))
    else $error("accepted beat not followed by decode step");

  a_calc_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |=> (state == S_COMMIT))
    else $error("calc step not followed by commit");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_COMMIT))
    else $error("result beat raised outside commit");
`endif

endmodule

[rtl/core/trb_dp.sv]
// Datapath: config registers, ring pointers and counters, trace store, result register.
// Depends on trb_pkg and trb_ram.
`timescale 1ns / 1ps

module trb_dp import trb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  trb_cmd_t             cmd,
  output trb_stat_t            stat,
  input  trb_in_t              in_data,
  output trb_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration
  logic [31:0] host_buffer_size;
  logic        trace_enable;

  // architectural state
  logic [LOCAL_AW-1:0] write_offset;
  logic [LOCAL_AW-1:0] read_offset;
  logic [31:0]         pending_bytes;
  logic [31:0]         excess_bytes;
  logic [31:0]         host_position;
  logic                copy_pending;
  logic [31:0]         event_total;
  // store entries at or above this count were never written and read as zero
  logic [CNT_W-1:0]    fill_count;

  // captured request and step registers
  trb_in_t             req;
  logic [31:0]         hp_wrap;
  logic [CNT_W-1:0]    avail;
  logic [31:0]         excess_calc;
  logic [CNT_W-1:0]    win;
  logic [CNT_W-1:0]    chunk;
  logic                flush_in_range;
  logic                flush_written;

  // prep step logic
  logic [LOCAL_AW-1:0] ring_gap;
  logic [CNT_W-1:0]    win_next;
  logic [31:0]         hp_wrap_next;
  logic [CNT_W-1:0]    avail_next;
  logic [31:0]         excess_calc_next;

  // calc step logic
  logic [31:0]         hroom;
  logic [CNT_W-1:0]    hsize;
  logic [CNT_W-1:0]    lroom;
  logic [CNT_W-1:0]    lsize;
  logic [LOCAL_AW-1:0] flush_pos;

  // commit logic
  logic                ev_ok;
  logic                ram_we;
  logic [LOCAL_AW-1:0] wo_next;
  logic [LOCAL_AW-1:0] ro_next;
  logic [31:0]         pend_next;
  logic [31:0]         exc_next;
  logic [31:0]         hp_next;
  logic                cp_next;
  logic [31:0]         tot_next;
  logic [CNT_W-1:0]    fill_next;
  logic [CNT_W-1:0]    ro_sum;
  trb_out_t            res;

  logic [LOCAL_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;

  assign stat.is_event = (req.req_type == REQ_EVENT) || (req.req_type == REQ_ATOMIC);

  // one port: reads in calc, writes in commit
  assign ram_addr = cmd.commit ? write_offset : flush_pos;

  trb_ram #(
    .WIDTH (8),
    .DEPTH (LOCAL_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit && ram_we),
    .addr  (ram_addr),
    .wdata (req.data_byte),
    .rdata (ram_rdata)
  );

  // prep: host wrap, ring clip, flush window length
  always_comb begin
    ring_gap     = write_offset - read_offset;
    hp_wrap_next = (host_position >= host_buffer_size) ? 32'd0 : host_position;
    if (pending_bytes > LOCAL_32) begin
      avail_next       = LOCAL_CNT;
      excess_calc_next = pending_bytes - LOCAL_32;
    end else begin
      avail_next       = pending_bytes[CNT_W-1:0];
      excess_calc_next = 32'd0;
    end
    if (pending_bytes > FLUSH_32) begin
      win_next = FLUSH_CNT;
    end else begin
      win_next = {1'b0, ring_gap};
      // equal pointers with data pending means a full ring
      if (ring_gap == '0 && pending_bytes != 32'd0) begin
        win_next = LOCAL_CNT;
      end
      if (win_next > FLUSH_CNT) begin
        win_next = FLUSH_CNT;
      end
    end
  end

  // calc: chunk bounded by host end and ring end; flush address
  always_comb begin
    hroom     = host_buffer_size - hp_wrap;
    hsize     = (hroom < 32'(avail)) ? hroom[CNT_W-1:0] : avail;
    lroom     = LOCAL_CNT - {1'b0, read_offset};
    lsize     = (lroom < avail) ? lroom : avail;
    flush_pos = write_offset - win[LOCAL_AW-1:0] + req.flush_index;
  end

  // commit: state update and result
  always_comb begin
    ev_ok     = (req.event_length != 16'd0) && (req.event_length <= MAX_EVENT_LEN);
    ram_we    = 1'b0;
    wo_next   = write_offset;
    ro_next   = read_offset;
    pend_next = pending_bytes;
    exc_next  = excess_bytes;
    hp_next   = host_position;
    cp_next   = copy_pending;
    tot_next  = event_total;
    fill_next = fill_count;
    ro_sum    = {1'b0, read_offset} + chunk;
    res       = '0;
    unique case (req.req_type)
      REQ_EVENT, REQ_ATOMIC: begin
        if (ev_ok) begin
          ram_we  = 1'b1;
          wo_next = write_offset + 1'b1;
          if (pending_bytes != 32'hFFFF_FFFF) begin
            pend_next = pending_bytes + 32'd1;
          end
          if (fill_count != LOCAL_CNT) begin
            fill_next = fill_count + 1'b1;
          end
          if (req.last_byte) begin
            tot_next = event_total + 32'd1;
            if (req.req_type == REQ_EVENT && !copy_pending && trace_enable &&
                pend_next >= HALF_LEVEL) begin
              res.drain_request = 1'b1;
              cp_next           = 1'b1;
            end
          end
        end else begin
          res.status = ST_REJECT;
        end
      end
      REQ_DRAIN: begin
        hp_next               = hp_wrap;
        res.copy_host_offset  = hp_wrap;
        res.copy_local_offset = read_offset;
        if (pending_bytes == 32'd0) begin
          res.status = ST_EMPTY;
        end else begin
          exc_next = excess_calc;
          cp_next  = 1'b0;
          if (req.dma_refused) begin
            res.status = ST_REFUSED;
          end else begin
            res.copy_size = chunk;
            hp_next       = hp_wrap + 32'(chunk);
            ro_next       = ro_sum[LOCAL_AW-1:0];
            if (chunk != '0) begin
              pend_next = (excess_calc != 32'd0) ? 32'(LOCAL_CNT - chunk)
                                                 : pending_bytes - 32'(chunk);
            end
          end
        end
      end
      REQ_FLUSH: begin
        res.flush_size = win;
        if (flush_in_range) begin
          res.flush_byte = flush_written ? ram_rdata : 8'd0;
        end else begin
          res.status = ST_FLUSH_RANGE;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.available_bytes = pend_next;
    res.overflow_bytes  = exc_next;
    res.message_count   = tot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_buffer_size <= 32'd0;
      trace_enable     <= 1'b0;
      write_offset     <= '0;
      read_offset      <= '0;
      pending_bytes    <= 32'd0;
      excess_bytes     <= 32'd0;
      host_position    <= 32'd0;
      copy_pending     <= 1'b0;
      event_total      <= 32'd0;
      fill_count       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HOST_SIZE: host_buffer_size <= cfg_data;
          CFG_TRACE_EN:  trace_enable     <= cfg_data[0];
          default:       trace_enable     <= trace_enable;
        endcase
      end
      if (cmd.commit) begin
        write_offset  <= wo_next;
        read_offset   <= ro_next;
        pending_bytes <= pend_next;
        excess_bytes  <= exc_next;
        host_position <= hp_next;
        copy_pending  <= cp_next;
        event_total   <= tot_next;
        fill_count    <= fill_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
    if (cmd.prep) begin
      hp_wrap     <= hp_wrap_next;
      avail       <= avail_next;
      excess_calc <= excess_calc_next;
      win         <= win_next;
    end
    if (cmd.calc) begin
      chunk          <= (hsize < lsize) ? hsize : lsize;
      flush_in_range <= {1'b0, req.flush_index} < win;
      flush_written  <= {1'b0, flush_pos} < fill_count;
    end
    if (cmd.commit) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= LOCAL_CNT)
    else $error("fill count past ring size");

  a_fill_tracks_wp: assert property (@(posedge clk) disable iff (rst)
    (fill_count != LOCAL_CNT) |-> (fill_count[LOCAL_AW-1:0] == write_offset))
    else $error("fill count out of step with write pointer");

  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.calc) |-> (chunk <= avail))
    else $error("drain chunk exceeds unsent bytes");
`endif

endmodule

[rtl/core/trace_ring_buffer_drain.sv]
// Top level of the trace ring buffer with host drain.
// Depends on trb_pkg, trb_ctrl, trb_dp, trb_ram.
`timescale 1ns / 1ps

// Each request beat steps through accept, decode and commit (event bytes) or
// through accept, decode, chunk/address calc and commit (drain ticks and flush
// reads), set by the controller sequence and the single-port 8 KiB trace
// store with its registered read. One item is in flight at a time; its result
// lands in an output register, and the next request is accepted while that
// result waits, but its commit holds until the previous result beat is taken.
// The store needs no clearing pass after reset: a fill count marks which
// entries were written, and unwritten entries read back as zero. Config
// writes are taken every cycle.
module trace_ring_buffer_drain import trb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  trb_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output trb_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  trb_cmd_t  cmd;
  trb_stat_t stat;

  assign cfg_ready = 1'b1;

  trb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  trb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[tb/trace_ring_buffer_drain_test.sv]
// Self-checking testbench for trace_ring_buffer_drain: queued request driver,
// result monitor and an in-order predictor of the ring, drain and flush logic.
// Depends on trb_pkg and the trace_ring_buffer_drain RTL.
`timescale 1ns / 1ps

module trace_ring_buffer_drain_test;
  import trb_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int FILL_BYTES     = 400;
  localparam int HOLD_AT_RESULT = 700;
  localparam int HOLD_CYCLES    = 500;
  localparam int REPORT_LIMIT   = 10;
  localparam int IN_W           = $bits(trb_in_t);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  trb_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  trb_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  always #6 clk = ~clk;

  trace_ring_buffer_drain DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block's registers and trace store
  logic [31:0]       hbuf_size_cfg = '0;
  logic              trace_en_cfg = 1'b0;
  bit [7:0]          shadow_store [LOCAL_SIZE];
  bit [LOCAL_AW-1:0] wr_ptr;
  bit [LOCAL_AW-1:0] rd_ptr;
  bit [31:0]         unsent;
  bit [31:0]         excess;
  bit [31:0]         host_pos;
  bit [31:0]         events_seen;
  bit                copy_busy;

  trb_in_t  trace_requests [$];
  trb_out_t expected_results [$];
  trb_out_t predicted_beat;
  trb_out_t wanted_beat;
  string    beat_diffs;

  int  items_queued = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet_phase = 1'b0;
  int  n_bytes = 0;
  int  n_drains = 0;
  int  n_overflow = 0;
  int  n_flushes = 0;
  int  n_requests = 0;

  function automatic trb_out_t predict_trace_result(trb_in_t req);
    trb_out_t          res;
    logic [31:0]       avail;
    logic [31:0]       hsize;
    logic [31:0]       lsize;
    logic [31:0]       chunk;
    logic [31:0]       window;
    logic [LOCAL_AW-1:0] ring_gap;
    logic [LOCAL_AW-1:0] pick;
    res = '0;
    case (req.req_type)
      REQ_EVENT, REQ_ATOMIC: begin
        if (req.event_length == 16'd0 || req.event_length > MAX_EVENT_LEN) begin
          res.status = ST_REJECT;
        end else begin
          shadow_store[wr_ptr] = req.data_byte;
          wr_ptr = wr_ptr + 1'b1;
          if (unsent != 32'hFFFF_FFFF) unsent = unsent + 32'd1;
          if (req.last_byte) begin
            events_seen = events_seen + 32'd1;
            if (req.req_type == REQ_EVENT && !copy_busy && trace_en_cfg &&
                unsent >= HALF_LEVEL) begin
              res.drain_request = 1'b1;
              copy_busy = 1'b1;
            end
          end
        end
      end
      REQ_DRAIN: begin
        if (host_pos >= hbuf_size_cfg) host_pos = '0;
        res.copy_host_offset  = host_pos;
        res.copy_local_offset = rd_ptr;
        if (unsent == 32'd0) begin
          res.status = ST_EMPTY;
        end else begin
          avail = unsent;
          if (avail > LOCAL_32) begin
            excess = avail - LOCAL_32;
            avail  = LOCAL_32;
          end else begin
            excess = '0;
          end
          hsize = avail;
          if ({1'b0, host_pos} + {1'b0, avail} > {1'b0, hbuf_size_cfg})
            hsize = hbuf_size_cfg - host_pos;
          lsize = avail;
          if (32'(rd_ptr) + avail > LOCAL_32) lsize = LOCAL_32 - 32'(rd_ptr);
          chunk = (hsize < lsize) ? hsize : lsize;
          if (req.dma_refused) begin
            res.status = ST_REFUSED;
          end else begin
            res.copy_size = chunk[13:0];
            host_pos = host_pos + chunk;
            rd_ptr   = rd_ptr + chunk[LOCAL_AW-1:0];
            if (chunk != 32'd0)
              unsent = (excess != 32'd0) ? LOCAL_32 - chunk : unsent - chunk;
          end
          copy_busy = 1'b0;
        end
      end
      default: begin
        if (unsent > FLUSH_32) begin
          window = FLUSH_32;
        end else begin
          ring_gap = wr_ptr - rd_ptr;
          window   = 32'(ring_gap);
          // equal pointers with bytes pending means a full ring
          if (window == 32'd0 && unsent != 32'd0) window = LOCAL_32;
          if (window > FLUSH_32) window = FLUSH_32;
        end
        res.flush_size = window[13:0];
        if (32'(req.flush_index) < window) begin
          pick = wr_ptr - window[LOCAL_AW-1:0] + req.flush_index;
          res.flush_byte = shadow_store[pick];
        end else begin
          res.status = ST_FLUSH_RANGE;
        end
      end
    endcase
    res.available_bytes = unsent;
    res.overflow_bytes  = excess;
    res.message_count   = events_seen;
    return res;
  endfunction

  function automatic string field_diffs(trb_out_t want, trb_out_t got);
    string s;
    s = "";
    if (got.status !== want.status)
      s = {s, $sformatf(" status exp %0d got %0d", want.status, got.status)};
    if (got.drain_request !== want.drain_request)
      s = {s, $sformatf(" drain_request exp %0d got %0d", want.drain_request,
                        got.drain_request)};
    if (got.copy_host_offset !== want.copy_host_offset)
      s = {s, $sformatf(" copy_host_offset exp %0h got %0h", want.copy_host_offset,
                        got.copy_host_offset)};
    if (got.copy_local_offset !== want.copy_local_offset)
      s = {s, $sformatf(" copy_local_offset exp %0h got %0h", want.copy_local_offset,
                        got.copy_local_offset)};
    if (got.copy_size !== want.copy_size)
      s = {s, $sformatf(" copy_size exp %0d got %0d", want.copy_size, got.copy_size)};
    if (got.available_bytes !== want.available_bytes)
      s = {s, $sformatf(" available_bytes exp %0d got %0d", want.available_bytes,
                        got.available_bytes)};
    if (got.overflow_bytes !== want.overflow_bytes)
      s = {s, $sformatf(" overflow_bytes exp %0d got %0d", want.overflow_bytes,
                        got.overflow_bytes)};
    if (got.message_count !== want.message_count)
      s = {s, $sformatf(" message_count exp %0d got %0d", want.message_count,
                        got.message_count)};
    if (got.flush_byte !== want.flush_byte)
      s = {s, $sformatf(" flush_byte exp %0h got %0h", want.flush_byte, got.flush_byte)};
    if (got.flush_size !== want.flush_size)
      s = {s, $sformatf(" flush_size exp %0d got %0d", want.flush_size, got.flush_size)};
    return s;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("MISMATCH at result beat %0d:%s", results_seen, what);
  endtask

  // request driver: one beat held until taken, random gaps between beats outside quiet phases
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_beat = predict_trace_result(in_data);
        expected_results.push_back(predicted_beat);
        case (in_data.req_type)
          REQ_DRAIN: begin
            n_drains++;
            if (predicted_beat.overflow_bytes != 32'd0) n_overflow++;
          end
          REQ_FLUSH: n_flushes++;
          default: begin
            if (predicted_beat.status == ST_OK) n_bytes++;
            if (predicted_beat.drain_request) n_requests++;
          end
        endcase
      end
      if (!in_valid || in_ready) begin
        if (trace_requests.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 6)) begin
          in_data  <= trace_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure outside quiet phases and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_mismatch(" result beat with nothing expected");
        end else begin
          wanted_beat = expected_results.pop_front();
          beat_diffs  = field_diffs(wanted_beat, out_data);
          if (beat_diffs != "") note_mismatch(beat_diffs);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen == HOLD_AT_RESULT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_phase || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  function automatic trb_in_t make_item(input logic [1:0] kind);
    trb_in_t it;
    it = trb_in_t'(IN_W'({$urandom, $urandom}));
    it.req_type = kind;
    return it;
  endfunction

  task automatic queue_byte(input logic [1:0] kind, input logic [7:0] value,
                            input logic [15:0] len, input logic last);
    trb_in_t it;
    it = make_item(kind);
    it.data_byte    = value;
    it.event_length = len;
    it.last_byte    = last;
    trace_requests.push_back(it);
    items_queued++;
  endtask

  task automatic queue_event(input logic [1:0] kind, input int nbytes,
                             input logic [15:0] len);
    for (int i = 0; i < nbytes; i++)
      queue_byte(kind, 8'($urandom), len, i == nbytes - 1);
  endtask

  task automatic queue_reject(input logic [1:0] kind, input logic [15:0] len);
    queue_byte(kind, 8'($urandom), len, 1'($urandom));
  endtask

  task automatic queue_drain(input logic refused);
    trb_in_t it;
    it = make_item(REQ_DRAIN);
    it.dma_refused = refused;
    trace_requests.push_back(it);
    items_queued++;
  endtask

  task automatic queue_flush(input logic [12:0] idx);
    trb_in_t it;
    it = make_item(REQ_FLUSH);
    it.flush_index = idx;
    trace_requests.push_back(it);
    items_queued++;
  endtask

  function automatic logic [1:0] pick_event_kind();
    return ($urandom_range(0, 4) == 0) ? REQ_ATOMIC : REQ_EVENT;
  endfunction

  // mostly well-formed events, drains and flushes; some rejects and odd lengths
  task automatic queue_random(input int count);
    int start;
    int pick;
    int nb;
    start = items_queued;
    while (items_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 12);
        queue_event(pick_event_kind(), nb, 16'(nb));
      end else if (pick < 65) begin
        queue_drain($urandom_range(0, 6) == 0);
      end else if (pick < 85) begin
        queue_flush(($urandom_range(0, 3) == 0) ? 13'($urandom) :
                    13'($urandom_range(0, 1100)));
      end else if (pick < 93) begin
        queue_reject(pick_event_kind(),
                     ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1025, 65535)));
      end else begin
        queue_byte(pick_event_kind(), 8'($urandom),
                   16'($urandom_range(1, MAX_EVENT_LEN)), 1'($urandom));
      end
    end
  endtask

  task automatic queue_fill(input int nbytes);
    int left;
    int nb;
    left = nbytes;
    while (left > 0) begin
      nb = $urandom_range(1, MAX_EVENT_LEN);
      if (nb > left) nb = left;
      queue_event(pick_event_kind(), nb, 16'(nb));
      left -= nb;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HOST_SIZE) hbuf_size_cfg = value;
    else trace_en_cfg = value[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (results_seen < items_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] hbuf_bytes, input logic enable,
                           input int count, input bit quiet);
    write_reg(CFG_HOST_SIZE, hbuf_bytes);
    write_reg(CFG_TRACE_EN, {31'd0, enable});
    quiet_phase = quiet;
    queue_random(count);
    settle();
    quiet_phase = 1'b0;
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("trace_ring_buffer_drain_test failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset config: host size 0, tracing off
    queue_drain(1'b0);                     // empty ring
    queue_flush(13'd0);                    // empty window
    queue_reject(REQ_EVENT, 16'd0);
    queue_reject(REQ_EVENT, 16'(MAX_EVENT_LEN + 16'd1));
    queue_reject(REQ_ATOMIC, 16'hFFFF);
    queue_byte(REQ_ATOMIC, 8'h00, 16'd2, 1'b0);
    queue_byte(REQ_ATOMIC, 8'hFF, 16'd2, 1'b1);
    queue_byte(REQ_EVENT, 8'hA5, MAX_EVENT_LEN, 1'b1);
    queue_byte(REQ_EVENT, 8'h5A, 16'd1, 1'b1);
    queue_drain(1'b0);                     // zero host size moves nothing
    queue_drain(1'b1);                     // refused copy
    queue_flush(13'd0);
    queue_flush(13'd3);
    queue_flush(13'd4);
    queue_flush(13'h1FFF);
    settle();

    // tiny host buffer: chunk bounded by host end, then host wrap
    write_reg(CFG_HOST_SIZE, 32'd3);
    write_reg(CFG_TRACE_EN, 32'd1);
    queue_drain(1'b0);
    queue_drain(1'b0);
    queue_drain(1'b0);
    queue_flush(13'd0);
    settle();

    run_phase(32'd37, 1'b1, RANDOM_ITEMS / 4, 1'b0);

    // huge host buffer: burst of long events, flush reads, then drain
    write_reg(CFG_HOST_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_TRACE_EN, 32'd1);
    queue_fill(FILL_BYTES);
    queue_flush(13'd0);
    queue_flush(13'($urandom_range(0, 1023)));
    queue_drain(1'b1);
    for (int i = 0; i < 4; i++) queue_drain(1'b0);
    queue_random(RANDOM_ITEMS / 4);
    settle();

    run_phase(32'd0, 1'b0, RANDOM_ITEMS / 4, 1'b1);
    run_phase($urandom_range(1, 9000), 1'($urandom), RANDOM_ITEMS / 4, 1'b0);

    if (expected_results.size() != 0)
      note_mismatch($sformatf(" %0d expected beats never arrived", expected_results.size()));
    $display("Covered %0d stored bytes, %0d drain ticks (%0d with overflow), %0d flush reads,",
             n_bytes, n_drains, n_overflow, n_flushes);
    $display("%0d half-full requests; %0d result beats checked, %0d mismatches",
             n_requests, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("trace_ring_buffer_drain_test passed");
    end else begin
      $display("trace_ring_buffer_drain_test failed");
    end
    $finish;
  end

endmodule
